FILE: design/dnsr_pkg.sv
// Package for the DNS fixed-answer responder.
// Holds channel payload types and the front-to-back command format.
// No dependencies.
package dnsr_pkg;

  // Upper bound on stored questions, sizes the command snapshot
  localparam int QSLOTS = 3;

  localparam logic [7:0] FLAG_QR      = 8'h80;
  localparam logic [7:0] FLAG_TC      = 8'h04;
  localparam logic [7:0] NAME_PTR     = 8'hC0;
  localparam logic [7:0] RESP_FLAGS   = 8'h80;
  localparam logic [7:0] RDLEN_LO     = 8'h04;
  localparam logic [9:0] HEADER_BYTES = 10'd12;

  // Configuration register indexes
  localparam logic [1:0] REG_ADDRESS = 2'd0;
  localparam logic [1:0] REG_TTL     = 2'd1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
    logic       drop;
  } out_t;

  // At most one command per accepted query byte: up to three literal bytes,
  // then an answer burst, then an optional drop marker.
  typedef struct packed {
    logic [2:0][7:0]         lit;
    logic [1:0]              lit_cnt;
    logic                    lit_last;
    logic [1:0]              ans_cnt;
    logic                    tail_drop;
    logic [QSLOTS-1:0][9:0]  off;
    logic [QSLOTS-1:0][31:0] tc;
  } cmd_t;

endpackage

FILE: design/dnsr_front.sv
// Front end: parses query bytes and turns them into reply commands.
// Depends on dnsr_pkg.
module dnsr_front #(
  parameter int MAX_QUESTIONS   = 3,
  parameter int MAX_REPLY_BYTES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  dnsr_pkg::in_t   in_data,
  output logic            push,
  output dnsr_pkg::cmd_t  cmd
);
  import dnsr_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_NAMELEN, PH_LABEL, PH_TAIL, PH_IGNORE
  } phase_t;

  phase_t      phase, phase_next;
  logic [10:0] pos, pos_next;
  logic [15:0] held_id, held_id_next;
  logic [15:0] qtotal, qtotal_next;
  logic [1:0]  qidx, qidx_next;
  logic [7:0]  label_rem, label_rem_next;
  logic [1:0]  tail_cnt, tail_cnt_next;
  logic [MAX_QUESTIONS-1:0][9:0]  qoff, qoff_next;
  logic [MAX_QUESTIONS-1:0][31:0] qtc, qtc_next;

  logic [7:0]  b;
  logic        eop;
  logic        finished;
  logic [20:0] reply_len;
  cmd_t        c;

  assign b   = in_data.payload_byte;
  assign eop = in_data.end_of_packet;
  // reply length if this byte were echoed
  assign reply_len = {10'd0, pos} + 21'd1 + {1'b0, qtotal, 4'd0};

  // byte classification and next state
  always_comb begin
    c              = '0;
    finished       = 1'b0;
    phase_next     = phase;
    pos_next       = pos;
    held_id_next   = held_id;
    qtotal_next    = qtotal;
    qidx_next      = qidx;
    label_rem_next = label_rem;
    tail_cnt_next  = tail_cnt;
    qoff_next      = qoff;
    qtc_next       = qtc;

    if (phase != PH_IGNORE) begin
      if (phase == PH_HEADER) begin
        case (pos)
          11'd0: held_id_next[15:8] = b;
          11'd1: held_id_next[7:0]  = b;
          11'd2: begin
            if ((b & (FLAG_QR | FLAG_TC)) != 8'd0) begin
              finished = 1'b1;
            end else begin
              c.lit     = {RESP_FLAGS, held_id[7:0], held_id[15:8]};
              c.lit_cnt = 2'd3;
            end
          end
          11'd4: begin
            qtotal_next = {b, 8'd0};
            c.lit[0]    = b;
            c.lit_cnt   = 2'd1;
          end
          11'd5: begin
            qtotal_next = {qtotal[15:8], b};
            c.lit[0]    = b;
            c.lit_cnt   = 2'd1;
            if ({qtotal[15:8], b} > 16'(MAX_QUESTIONS)) begin
              c.tail_drop = 1'b1;
              finished    = 1'b1;
            end
          end
          11'd6: begin
            c.lit[0]  = qtotal[15:8];
            c.lit_cnt = 2'd1;
          end
          11'd7: begin
            c.lit[0]  = qtotal[7:0];
            c.lit_cnt = 2'd1;
          end
          11'd11: begin
            c.lit_cnt = 2'd1;
            if (qtotal == 16'd0) begin
              c.lit_last = 1'b1;
              finished   = 1'b1;
            end else begin
              phase_next   = PH_NAMELEN;
              qidx_next    = 2'd0;
              qoff_next[0] = HEADER_BYTES;
            end
          end
          default: c.lit_cnt = 2'd1;
        endcase
      end else if (reply_len > 21'(MAX_REPLY_BYTES)) begin
        c.tail_drop = 1'b1;
        finished    = 1'b1;
      end else if (phase == PH_NAMELEN) begin
        c.lit[0]  = b;
        c.lit_cnt = 2'd1;
        if (b == 8'd0) begin
          phase_next    = PH_TAIL;
          tail_cnt_next = 2'd0;
        end else begin
          phase_next     = PH_LABEL;
          label_rem_next = b;
        end
      end else if (phase == PH_LABEL) begin
        c.lit[0]       = b;
        c.lit_cnt      = 2'd1;
        label_rem_next = label_rem - 8'd1;
        if (label_rem_next == 8'd0) phase_next = PH_NAMELEN;
      end else begin
        // type and class bytes
        c.lit[0]      = b;
        c.lit_cnt     = 2'd1;
        tail_cnt_next = tail_cnt + 2'd1;
        if (32'(qidx) < 32'(MAX_QUESTIONS)) qtc_next[qidx] = {qtc[qidx][23:0], b};
        if (tail_cnt == 2'd3) begin
          qidx_next = qidx + 2'd1;
          if ({14'd0, qidx_next} >= qtotal) begin
            c.ans_cnt = qtotal[1:0];
            finished  = 1'b1;
          end else begin
            phase_next = PH_NAMELEN;
            if (32'(qidx_next) < 32'(MAX_QUESTIONS)) qoff_next[qidx_next] = pos[9:0] + 10'd1;
          end
        end
      end

      if (finished) begin
        phase_next = eop ? PH_HEADER : PH_IGNORE;
      end else if (eop) begin
        c.tail_drop = 1'b1;
      end else begin
        pos_next = pos + 11'd1;
      end
    end

    if (eop) begin
      phase_next     = PH_HEADER;
      pos_next       = 11'd0;
      qidx_next      = 2'd0;
      label_rem_next = 8'd0;
      tail_cnt_next  = 2'd0;
    end

    // snapshot of the question stores for the answer burst
    for (int i = 0; i < MAX_QUESTIONS; i++) begin
      c.off[i] = qoff_next[i];
      c.tc[i]  = qtc_next[i];
    end
  end

  assign cmd  = c;
  assign push = accept && (c.lit_cnt != 2'd0 || c.ans_cnt != 2'd0 || c.tail_drop);

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      pos       <= '0;
      held_id   <= '0;
      qtotal    <= '0;
      qidx      <= '0;
      label_rem <= '0;
      tail_cnt  <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      pos       <= pos_next;
      held_id   <= held_id_next;
      qtotal    <= qtotal_next;
      qidx      <= qidx_next;
      label_rem <= label_rem_next;
      tail_cnt  <= tail_cnt_next;
    end
  end

  // question stores, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      qoff <= qoff_next;
      qtc  <= qtc_next;
    end
  end

endmodule

FILE: design/dnsr_cmd_fifo.sv
// Two-entry command queue between the parser and the reply generator.
// Depends on dnsr_pkg.
module dnsr_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dnsr_pkg::cmd_t  wr_cmd,
  output logic            full,
  output logic            avail,
  input  logic            pop,
  output dnsr_pkg::cmd_t  rd_cmd
);
  import dnsr_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign avail  = (count != 2'd0);
  assign rd_cmd = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("command pushed into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("command popped from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

FILE: design/dnsr_back.sv
// Back end: expands commands into reply beats behind an output register.
// Depends on dnsr_pkg.
module dnsr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_avail,
  input  dnsr_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  input  logic [31:0]     answer_address,
  input  logic [31:0]     answer_ttl,
  output logic            out_valid,
  input  logic            out_stall,
  output dnsr_pkg::out_t  out_data
);
  import dnsr_pkg::*;

  typedef enum logic [1:0] {ST_LIT, ST_ANS, ST_DROP} stage_t;

  stage_t     stage;
  logic [1:0] lit_i;
  logic [1:0] ans_i;
  logic [3:0] ans_k;

  logic       slot_free;
  logic       go;
  logic       emit;
  out_t       beat;
  logic [7:0] ans_byte;
  logic [9:0] off;
  logic [31:0] tc;

  assign slot_free = !out_valid || !out_stall;
  assign go        = cmd_avail && slot_free;
  assign off       = cmd.off[ans_i];
  assign tc        = cmd.tc[ans_i];

  // answer record byte select
  always_comb begin
    case (ans_k)
      4'd0:    ans_byte = NAME_PTR | {6'd0, off[9:8]};
      4'd1:    ans_byte = off[7:0];
      4'd2:    ans_byte = tc[31:24];
      4'd3:    ans_byte = tc[23:16];
      4'd4:    ans_byte = tc[15:8];
      4'd5:    ans_byte = tc[7:0];
      4'd6:    ans_byte = answer_ttl[31:24];
      4'd7:    ans_byte = answer_ttl[23:16];
      4'd8:    ans_byte = answer_ttl[15:8];
      4'd9:    ans_byte = answer_ttl[7:0];
      4'd10:   ans_byte = 8'd0;
      4'd11:   ans_byte = RDLEN_LO;
      4'd12:   ans_byte = answer_address[31:24];
      4'd13:   ans_byte = answer_address[23:16];
      4'd14:   ans_byte = answer_address[15:8];
      default: ans_byte = answer_address[7:0];
    endcase
  end

  // current beat of the command
  always_comb begin
    emit    = 1'b0;
    beat    = '0;
    cmd_pop = 1'b0;
    case (stage)
      ST_LIT: begin
        if (lit_i < cmd.lit_cnt) begin
          emit            = 1'b1;
          beat.reply_byte = cmd.lit[lit_i];
          beat.reply_last = cmd.lit_last && (lit_i == cmd.lit_cnt - 2'd1);
        end
      end
      ST_ANS: begin
        if (cmd.ans_cnt != 2'd0) begin
          emit            = 1'b1;
          beat.reply_byte = ans_byte;
          beat.reply_last = (ans_k == 4'd15) && (ans_i == cmd.ans_cnt - 2'd1);
        end
      end
      ST_DROP: begin
        cmd_pop = go;
        if (cmd.tail_drop) begin
          emit            = 1'b1;
          beat.reply_last = 1'b1;
          beat.drop       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= ST_LIT;
      lit_i     <= '0;
      ans_i     <= '0;
      ans_k     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (slot_free) out_valid <= go && emit;
      if (go) begin
        if (emit) out_data <= beat;
        case (stage)
          ST_LIT: begin
            if (emit) lit_i <= lit_i + 2'd1;
            else      stage <= ST_ANS;
          end
          ST_ANS: begin
            if (!emit) begin
              stage <= ST_DROP;
            end else if (ans_k == 4'd15) begin
              ans_k <= '0;
              if (ans_i == cmd.ans_cnt - 2'd1) stage <= ST_DROP;
              else                             ans_i <= ans_i + 2'd1;
            end else begin
              ans_k <= ans_k + 4'd1;
            end
          end
          ST_DROP: begin
            stage <= ST_LIT;
            lit_i <= '0;
            ans_i <= '0;
            ans_k <= '0;
          end
          default: stage <= ST_LIT;
        endcase
      end
    end
  end

endmodule

FILE: design/dns_query_fixed_answer_responder_top.sv
// Top level of the DNS fixed-answer responder: config registers, parser,
// command queue and reply generator. Depends on dnsr_pkg and its submodules.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data (payload_byte, end_of_packet)
//  out     | output    | out_valid/out_stall| out_data (reply_byte, reply_last, drop)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A query byte is taken each cycle while the command queue has room.
// Each command is expanded into its literal, answer and drop beats in turn;
// the final tail byte expands into 1 + 16 per question beats, which holds
// off input once the two-entry queue fills.
// rst is synchronous; it restores the config defaults and idles both ends.
// out_stall holds the output register; the two-entry queue takes commands until full.
module dns_query_fixed_answer_responder_top #(
  parameter int MAX_QUESTIONS   = 3,
  parameter int MAX_REPLY_BYTES = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  dnsr_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dnsr_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import dnsr_pkg::*;

  logic [31:0] answer_address;
  logic [31:0] answer_ttl;
  logic        full, avail, push, pop, accept;
  cmd_t        wr_cmd, rd_cmd;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= 32'hC0A80401;
      answer_ttl     <= 32'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ADDRESS: answer_address <= cfg_data;
        REG_TTL:     answer_ttl     <= cfg_data;
        default: ;
      endcase
    end
  end

  dnsr_front #(
    .MAX_QUESTIONS  (MAX_QUESTIONS),
    .MAX_REPLY_BYTES(MAX_REPLY_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .in_data(in_data),
    .push   (push),
    .cmd    (wr_cmd)
  );

  dnsr_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr_cmd(wr_cmd),
    .full  (full),
    .avail (avail),
    .pop   (pop),
    .rd_cmd(rd_cmd)
  );

  dnsr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_avail     (avail),
    .cmd           (rd_cmd),
    .cmd_pop       (pop),
    .answer_address(answer_address),
    .answer_ttl    (answer_ttl),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

FILE: tb/sv/tb_dnsr_checker.sv
// Reply checker for the DNS fixed-answer responder: watches the query, reply and
// register channels, predicts each reply beat and compares. Depends on dnsr_pkg.
`timescale 1ns / 100ps
module tb_dnsr_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  dnsr_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  dnsr_pkg::out_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  output int             fail_count,
  output int             pending_beats
);
  import dnsr_pkg::*;

  typedef enum logic [2:0] {
    ST_HDR, ST_NLEN, ST_LABEL, ST_TAIL, ST_SKIP
  } walk_t;

  localparam int MAXQ  = 3;
  localparam int MAXRB = 1024;

  logic [31:0] addr_reg, ttl_reg;
  walk_t       st;
  int unsigned pos, qtotal, qidx, lrem, tcnt;
  logic [15:0] id_hold;
  logic [9:0]  qoff [MAXQ];
  logic [31:0] qtc  [MAXQ];
  out_t        reply_q [$];

  function automatic out_t mk(logic [7:0] b, logic l, logic d);
    out_t o;
    o.reply_byte = b; o.reply_last = l; o.drop = d;
    return o;
  endfunction

  task automatic push_word(logic [31:0] w);
    reply_q.push_back(mk(w[31:24], 0, 0));
    reply_q.push_back(mk(w[23:16], 0, 0));
    reply_q.push_back(mk(w[15:8], 0, 0));
    reply_q.push_back(mk(w[7:0], 0, 0));
  endtask

  task automatic restart();
    st = ST_HDR; pos = 0; qidx = 0; lrem = 0; tcnt = 0;
  endtask

  // Advance the responder model by one query byte
  task automatic predict_query_byte(logic [7:0] b, logic eop);
    logic done;
    int unsigned p;
    done = 0;
    p = pos;
    if (st == ST_SKIP) begin
      if (eop) restart();
      return;
    end
    if (st == ST_HDR) begin
      case (p)
        0: id_hold[15:8] = b;
        1: id_hold[7:0] = b;
        2: begin
          if ((b & (FLAG_QR | FLAG_TC)) != 0) done = 1;
          else begin
            reply_q.push_back(mk(id_hold[15:8], 0, 0));
            reply_q.push_back(mk(id_hold[7:0], 0, 0));
            reply_q.push_back(mk(RESP_FLAGS, 0, 0));
          end
        end
        4: begin qtotal = {b, 8'h00}; reply_q.push_back(mk(b, 0, 0)); end
        5: begin
          qtotal = (qtotal & 32'hFF00) | b;
          reply_q.push_back(mk(b, 0, 0));
          if (qtotal > MAXQ) begin reply_q.push_back(mk(0, 1, 1)); done = 1; end
        end
        6: reply_q.push_back(mk(qtotal[15:8], 0, 0));
        7: reply_q.push_back(mk(qtotal[7:0], 0, 0));
        11: begin
          if (qtotal == 0) begin reply_q.push_back(mk(0, 1, 0)); done = 1; end
          else begin
            reply_q.push_back(mk(0, 0, 0));
            st = ST_NLEN; qidx = 0; qoff[0] = HEADER_BYTES;
          end
        end
        default: reply_q.push_back(mk(0, 0, 0));
      endcase
    end else if (p + 1 + 16 * qtotal > MAXRB) begin
      reply_q.push_back(mk(0, 1, 1)); done = 1;
    end else if (st == ST_NLEN) begin
      reply_q.push_back(mk(b, 0, 0));
      if (b == 0) begin st = ST_TAIL; tcnt = 0; end
      else begin st = ST_LABEL; lrem = b; end
    end else if (st == ST_LABEL) begin
      reply_q.push_back(mk(b, 0, 0));
      lrem = (lrem - 1) & 8'hFF;
      if (lrem == 0) st = ST_NLEN;
    end else begin
      qtc[qidx] = {qtc[qidx][23:0], b};
      reply_q.push_back(mk(b, 0, 0));
      if (tcnt == 3) begin
        qidx = qidx + 1;
        if (qidx >= qtotal) begin
          // answer burst, one 16-byte record per question
          for (int i = 0; i < qtotal; i++) begin
            reply_q.push_back(mk(NAME_PTR | qoff[i][9:8], 0, 0));
            reply_q.push_back(mk(qoff[i][7:0], 0, 0));
            push_word(qtc[i]);
            push_word(ttl_reg);
            reply_q.push_back(mk(0, 0, 0));
            reply_q.push_back(mk(RDLEN_LO, 0, 0));
            reply_q.push_back(mk(addr_reg[31:24], 0, 0));
            reply_q.push_back(mk(addr_reg[23:16], 0, 0));
            reply_q.push_back(mk(addr_reg[15:8], 0, 0));
            reply_q.push_back(mk(addr_reg[7:0], i + 1 == qtotal, 0));
          end
          done = 1;
        end else begin
          st = ST_NLEN;
          qoff[qidx] = (p + 1) & 10'h3FF;
        end
      end
      tcnt = (tcnt + 1) & 3;
    end
    if (done) begin
      if (eop) restart(); else st = ST_SKIP;
    end else if (eop) begin
      reply_q.push_back(mk(0, 1, 1));
      restart();
    end else pos = (p + 1) & 11'h7FF;
  endtask

  assign pending_beats = reply_q.size();

  always @(posedge clk) begin
    out_t exp_beat;
    if (rst) begin
      addr_reg = 32'hC0A80401; ttl_reg = 32'd1;
      qtotal = 0; id_hold = 0;
      restart();
      reply_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ADDRESS) addr_reg = cfg_data;
        else if (cfg_index == REG_TTL) ttl_reg = cfg_data;
      end
      // compare reply beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("unexpected reply beat %h", out_data);
          fail_count++;
        end else begin
          exp_beat = reply_q.pop_front();
          if (out_data.drop !== exp_beat.drop) begin
            $error("drop exp %0d got %0d", exp_beat.drop, out_data.drop); fail_count++;
          end
          if (out_data.reply_last !== exp_beat.reply_last) begin
            $error("reply_last exp %0d got %0d", exp_beat.reply_last, out_data.reply_last);
            fail_count++;
          end
          if (out_data.reply_byte !== exp_beat.reply_byte) begin
            $error("reply_byte exp %h got %h", exp_beat.reply_byte, out_data.reply_byte);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_query_byte(in_data.payload_byte, in_data.end_of_packet);
    end
  end
endmodule

FILE: tb/sv/tb_top.sv
// Top of the DNS responder testbench: clock, reset, query and register stimulus,
// verdict. Depends on dnsr_pkg, the responder top and tb_dnsr_checker.
`timescale 1ns / 100ps
module tb_top;
  import dnsr_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  in_t  in_data = '0;
  out_t out_data;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0]  cfg_index = REG_ADDRESS;
  logic [31:0] cfg_data = 0;
  int fail_count, pending_beats;
  int idle_cnt = 0;
  bit calm = 0;
  int items_sent = 0;
  logic [7:0] pkt [$];

  always #2 clk = ~clk;

  dns_query_fixed_answer_responder_top DUT (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tb_dnsr_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending_beats
  );

  // receiver stalls in random bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = $urandom_range(1, 15);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1; repeat (n) @(posedge clk);
        out_stall <= 0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) || rst)
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WATCH_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(logic [7:0] b, logic eop);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1;
    in_data.payload_byte <= b;
    in_data.end_of_packet <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_pkt();
    for (int i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == pkt.size() - 1);
    in_valid <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // well-formed query with nq questions and the given flags; label content random
  task automatic build_query(int nq, logic [7:0] flags, int maxlab);
    int nl, ll;
    pkt.delete();
    pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom));
    pkt.push_back(flags); pkt.push_back(8'($urandom));
    pkt.push_back(8'(nq >> 8)); pkt.push_back(8'(nq));
    repeat (6) pkt.push_back(8'($urandom));
    for (int q = 0; q < nq; q++) begin
      nl = $urandom_range(0, 3);
      repeat (nl) begin
        ll = $urandom_range(1, maxlab);
        pkt.push_back(8'(ll));
        repeat (ll) pkt.push_back(8'($urandom));
      end
      pkt.push_back(8'd0);
      repeat (4) pkt.push_back(8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
  endtask

  function automatic logic [7:0] ok_flags();
    return 8'($urandom) & ~(FLAG_QR | FLAG_TC);
  endfunction

  initial begin
    int k, cut;
    logic [15:0] big_count;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, zero questions, max questions, flags, counts
    build_query(1, 8'h00, 4); send_pkt();
    build_query(0, 8'h7B, 4); send_pkt();
    build_query(3, 8'h00, 8); send_pkt();
    build_query(1, FLAG_QR, 4); send_pkt();
    build_query(1, FLAG_TC, 4); send_pkt();
    build_query(4, 8'h00, 4); send_pkt();
    build_query(1, 8'h00, 4); pkt[4] = 8'h01; send_pkt();
    // truncated inside ID, header and question
    pkt = '{8'hFF}; send_pkt();
    pkt = '{8'h12, 8'h34}; send_pkt();
    build_query(2, 8'h00, 4); pkt = pkt[0:8]; send_pkt();
    build_query(2, 8'h00, 4); pkt = pkt[0:pkt.size() - 3]; send_pkt();
    // overflow: one long question with big labels
    pkt.delete();
    pkt = '{8'hAB, 8'hCD, 8'h01, 8'h00, 8'h00, 8'h01, 0, 0, 0, 0, 0, 0};
    repeat (4) begin
      pkt.push_back(8'hFF);
      repeat (255) pkt.push_back(8'($urandom));
    end
    pkt.push_back(8'd0);
    send_pkt();
    drain();

    write_reg(REG_ADDRESS, 32'hFFFFFFFF); write_reg(REG_TTL, 32'hFFFFFFFF);
    write_reg(2'd3, 32'h12345678);
    build_query(2, 8'h00, 4); send_pkt();
    drain();
    write_reg(REG_ADDRESS, 32'h0); write_reg(REG_TTL, 32'h0);
    build_query(3, 8'h00, 4); send_pkt();
    drain();

    // random phases, each with fresh register values
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_ADDRESS, $urandom); write_reg(REG_TTL, $urandom);
      k = 0;
      while (k < 90) begin
        if (ph == 4) calm = 1;
        case ($urandom_range(0, 9))
          0: begin
            pkt.delete();
            repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom));
          end
          1: build_query($urandom_range(0, 3), 8'($urandom), 6);
          2: begin
            build_query($urandom_range(1, 3), ok_flags(), 6);
            cut = $urandom_range(1, pkt.size());
            pkt = pkt[0:cut - 1];
          end
          3: begin
            // short body under a question count that is too large
            build_query($urandom_range(1, 3), ok_flags(), 6);
            big_count = 16'($urandom_range(4, 300));
            pkt[4] = big_count[15:8];
            pkt[5] = big_count[7:0];
          end
          default: build_query($urandom_range(0, 3), ok_flags(), 6);
        endcase
        send_pkt();
        k += pkt.size();
      end
      drain();
    end

    drain();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
